[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, clocked, skipped while reset is held
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check, clocked, also active through reset
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/gzsf_pkg.sv]
`default_nettype none

package gzsf_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_SEED = 32'hFFFFFFFF;

    typedef logic [31:0] t_crc_table [256];

    function automatic t_crc_table f_crc_table();
        t_crc_table tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = f_crc_table();

    // work for the back end: which groups of bytes to send for one input word
    typedef struct packed {
        logic        has_hdr;
        logic        has_blk;
        logic        blk_final;
        logic        has_data;
        logic        has_trl;
        logic        overrun;
        logic [15:0] chunk;
        logic [7:0]  data;
        logic [31:0] crc;
        logic [31:0] len;
    } t_cmd;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

endpackage

`default_nettype wire

[src/gzip_stored_block_framer.sv]
// path: an input word is written into the queue, then its first output byte is registered at the output
// throughput: one input word per cycle when each gives one output byte;
//   a word that opens a block gives 6 bytes, the last gives 8 more, a start 10 or 23;
//   the single byte-wide output sets the pace, input stalls once the 4-word queue is full
// reset: synchronous active low, crc to all ones, counts and queue cleared
`default_nettype none

module gzip_stored_block_framer import gzsf_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic        i_s_axis_tuser,   // action
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte
    output logic             o_m_axis_tlast,   // run_last
    output logic [1:0]       o_m_axis_tuser    // stream_end, overrun
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    gzsf_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_action      (i_s_axis_tuser),
        .i_data        (i_s_axis_tdata),
        .i_full        (q_full),
        .o_ready       (o_s_axis_tready),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    gzsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    gzsf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

[src/gzsf_front.sv]
`default_nettype none

module gzsf_front import gzsf_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_full,
    output logic             o_ready,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam logic [15:0] MAX_B = 16'(MAX_BLOCK_BYTES);

    logic [31:0] r_len_cfg;
    logic [31:0] r_crc,   n_crc;
    logic [31:0] r_taken, n_taken;
    logic [15:0] r_left,  n_left;

    logic [31:0] remaining;
    logic [31:0] crc_upd;
    logic        fits;

    assign o_ready   = !i_full;
    assign o_push    = i_valid && !i_full;
    assign remaining = r_len_cfg - r_taken;
    assign fits      = remaining <= {16'h0, MAX_B};
    assign crc_upd   = CRC_TABLE[r_crc[7:0] ^ i_data] ^ {8'h00, r_crc[31:8]};

    always_comb begin
        n_crc   = r_crc;
        n_taken = r_taken;
        n_left  = r_left;
        o_cmd   = '0;
        if (!i_action) begin
            n_crc         = CRC_SEED;
            n_taken       = '0;
            n_left        = '0;
            o_cmd.has_hdr = 1'b1;
            if (r_len_cfg == '0) begin
                // empty payload: final empty block and trailer of nothing
                o_cmd.has_blk   = 1'b1;
                o_cmd.blk_final = 1'b1;
                o_cmd.has_trl   = 1'b1;
            end
        end else if (r_taken >= r_len_cfg) begin
            o_cmd.has_data = 1'b1;
            o_cmd.overrun  = 1'b1;
        end else begin
            o_cmd.has_data = 1'b1;
            o_cmd.data     = i_data;
            n_crc          = crc_upd;
            n_taken        = r_taken + 32'd1;
            if (r_left == '0) begin
                o_cmd.has_blk   = 1'b1;
                o_cmd.blk_final = fits;
                o_cmd.chunk     = fits ? remaining[15:0] : MAX_B;
                n_left          = (fits ? remaining[15:0] : MAX_B) - 16'd1;
            end else begin
                n_left = r_left - 16'd1;
            end
            if (remaining == 32'd1) begin
                o_cmd.has_trl = 1'b1;
                o_cmd.crc     = ~crc_upd;
                o_cmd.len     = r_len_cfg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= '0;
            r_crc     <= CRC_SEED;
            r_taken   <= '0;
            r_left    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len_cfg <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_crc   <= n_crc;
                r_taken <= n_taken;
                r_left  <= n_left;
            end
        end
    end

endmodule

`default_nettype wire

[src/gzsf_queue.sv]
`default_nettype none

module gzsf_queue import gzsf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/gzsf_back.sv]
`default_nettype none

module gzsf_back import gzsf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_cmd i_head,
    output logic      o_pop,
    output logic       o_tvalid,
    input  wire logic  i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast,
    output logic [1:0] o_tuser
);

    // byte slots of one command: gzip header, block header, data, trailer
    localparam logic [4:0] P_HDR0    = 5'd0;
    localparam logic [4:0] P_HDR_END = 5'd9;
    localparam logic [4:0] P_BLK0    = 5'd10;
    localparam logic [4:0] P_BLK_END = 5'd14;
    localparam logic [4:0] P_DATA    = 5'd15;
    localparam logic [4:0] P_TRL0    = 5'd16;
    localparam logic [4:0] P_TRL_END = 5'd23;

    function automatic logic [7:0] f_gz_header(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h1f;
            4'd1:    b = 8'h8b;
            4'd2:    b = 8'h08;
            4'd9:    b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    logic [4:0] r_pos;
    logic       r_mid;
    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic [1:0] r_tuser;

    logic [4:0] first_pos;
    logic [4:0] cur_pos;
    logic [4:0] next_pos;
    logic       is_last;
    logic       advance;
    logic [7:0] byte_out;
    logic [2:0] trl_sel;
    logic [63:0] trl_word;
    logic [15:0] nchunk;

    always_comb begin
        if (i_head.has_hdr) begin
            first_pos = P_HDR0;
        end else if (i_head.has_blk) begin
            first_pos = P_BLK0;
        end else if (i_head.has_data) begin
            first_pos = P_DATA;
        end else begin
            first_pos = P_TRL0;
        end
    end

    assign cur_pos = r_mid ? r_pos : first_pos;

    // step to the next slot that this command uses
    always_comb begin
        next_pos = cur_pos + 5'd1;
        is_last  = 1'b0;
        if (cur_pos == P_HDR_END) begin
            if (i_head.has_blk) begin
                next_pos = P_BLK0;
            end else if (i_head.has_data) begin
                next_pos = P_DATA;
            end else if (i_head.has_trl) begin
                next_pos = P_TRL0;
            end else begin
                is_last = 1'b1;
            end
        end else if (cur_pos == P_BLK_END) begin
            if (i_head.has_data) begin
                next_pos = P_DATA;
            end else if (i_head.has_trl) begin
                next_pos = P_TRL0;
            end else begin
                is_last = 1'b1;
            end
        end else if (cur_pos == P_DATA) begin
            is_last = !i_head.has_trl;
        end else if (cur_pos == P_TRL_END) begin
            is_last = 1'b1;
        end
    end

    assign nchunk   = ~i_head.chunk;
    assign trl_sel  = 3'(cur_pos - P_TRL0);
    assign trl_word = {i_head.len, i_head.crc};

    always_comb begin
        if (cur_pos <= P_HDR_END) begin
            byte_out = f_gz_header(cur_pos[3:0]);
        end else if (cur_pos == P_BLK0) begin
            byte_out = {7'h00, i_head.blk_final};
        end else if (cur_pos == P_BLK0 + 5'd1) begin
            byte_out = i_head.chunk[7:0];
        end else if (cur_pos == P_BLK0 + 5'd2) begin
            byte_out = i_head.chunk[15:8];
        end else if (cur_pos == P_BLK0 + 5'd3) begin
            byte_out = nchunk[7:0];
        end else if (cur_pos == P_BLK_END) begin
            byte_out = nchunk[15:8];
        end else if (cur_pos == P_DATA) begin
            byte_out = i_head.data;
        end else begin
            byte_out = trl_word[{trl_sel, 3'b000} +: 8];
        end
    end

    assign advance  = !i_empty && (!r_tvalid || i_tready);
    assign o_pop    = advance && is_last;
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= P_HDR0;
            r_mid    <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (advance) begin
                r_tvalid <= 1'b1;
                r_mid    <= !is_last;
                r_pos    <= next_pos;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tdata    <= byte_out;
            r_tlast    <= is_last;
            r_tuser[0] <= cur_pos == P_TRL_END;
            r_tuser[1] <= i_head.overrun;
        end
    end

endmodule

`default_nettype wire

[src/gzsf_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module gzsf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast,
    input wire logic [1:0] o_m_axis_tuser
);

    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "output word dropped or changed while stalled")
    `ASSERT_CLK_RST(a_overrun_word, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == 8'h00 && o_m_axis_tlast && !o_m_axis_tuser[0], "overrun word malformed")
    `ASSERT_CLK_RST(a_end_is_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast, "stream end not on last word of run")
    `ASSERT_CLK(a_reset_idle, i_clk, !$past(i_rst_n) |-> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind gzip_stored_block_framer gzsf_checker u_gzsf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {ACT_START = 1'b0, ACT_DATA = 1'b1} t_action;

    typedef struct {
        logic [7:0] out_byte;
        bit         run_last;
        bit         stream_end;
        bit         overrun;
    } t_gz_word;

    localparam logic [31:0] CRC_REFL_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [31:0] BLOCK_MAX     = 32'd65535;
    localparam int          TARGET_WORDS  = 330;
    localparam longint      CYCLE_LIMIT   = 1_000_000;
    localparam logic [7:0]  GZ_HEADER [10] =
        '{8'h1f, 8'h8b, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff};

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // predictor state
    logic [31:0] cfg_length;
    logic [31:0] crc_acc;
    logic [31:0] taken_count;
    logic [15:0] block_left;
    logic [7:0]  frame_bytes [$];
    t_gz_word    gz_expected [$];

    int     errors;
    int     words_sent;
    longint cycles;
    bit     tx_calm;
    bit     rx_calm;
    int     rx_hold;
    int     rx_stall;

    gzip_stored_block_framer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, gz_expected.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_REFL_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void frame_block_header(logic [15:0] chunk, bit is_final);
        logic [15:0] inv;
        inv = ~chunk;
        frame_bytes.push_back(is_final ? 8'h01 : 8'h00);
        frame_bytes.push_back(chunk[7:0]);
        frame_bytes.push_back(chunk[15:8]);
        frame_bytes.push_back(inv[7:0]);
        frame_bytes.push_back(inv[15:8]);
    endfunction

    function automatic void frame_trailer();
        logic [31:0] crc_out;
        crc_out = crc_acc ^ CRC_ALL_ONES;
        for (int s = 0; s < 32; s += 8)
            frame_bytes.push_back(crc_out[s +: 8]);
        for (int s = 0; s < 32; s += 8)
            frame_bytes.push_back(taken_count[s +: 8]);
    endfunction

    // works out the gzip bytes one accepted word gives and queues them
    function automatic void predict_gz_words(t_action act, logic [7:0] b);
        logic [31:0] remaining;
        logic [31:0] chunk;
        bit          has_end;
        bit          ovr;
        t_gz_word    w;
        has_end = 0;
        ovr = 0;
        frame_bytes.delete();
        if (act == ACT_START) begin
            crc_acc = CRC_ALL_ONES;
            taken_count = '0;
            block_left = '0;
            foreach (GZ_HEADER[i])
                frame_bytes.push_back(GZ_HEADER[i]);
            if (cfg_length == 0) begin
                frame_block_header(16'd0, 1'b1);
                frame_trailer();
                has_end = 1;
            end
        end else if (taken_count >= cfg_length) begin
            frame_bytes.push_back(8'h00);
            ovr = 1;
        end else begin
            remaining = cfg_length - taken_count;
            if (block_left == 0) begin
                chunk = (remaining > BLOCK_MAX) ? BLOCK_MAX : remaining;
                frame_block_header(chunk[15:0], chunk == remaining);
                block_left = chunk[15:0];
            end
            frame_bytes.push_back(b);
            crc_acc = crc_byte(crc_acc, b);
            block_left = block_left - 16'd1;
            taken_count = taken_count + 1;
            if (taken_count == cfg_length) begin
                frame_trailer();
                has_end = 1;
            end
        end
        foreach (frame_bytes[i]) begin
            w.out_byte   = frame_bytes[i];
            w.run_last   = (i == frame_bytes.size() - 1);
            w.stream_end = has_end && (i == frame_bytes.size() - 1);
            w.overrun    = ovr;
            gz_expected.push_back(w);
        end
    endfunction

    // checks each word taken from the master side against the oldest prediction
    always @(posedge clk) begin
        t_gz_word w;
        if (rst_n && m_tvalid && m_tready) begin
            if (gz_expected.size() == 0) begin
                report("word with nothing expected", m_tdata, 0);
            end else begin
                w = gz_expected.pop_front();
                if (m_tdata !== w.out_byte)
                    report("out_byte", m_tdata, w.out_byte);
                if (m_tlast !== w.run_last)
                    report("run_last", m_tlast, w.run_last);
                if (m_tuser[0] !== w.stream_end)
                    report("stream_end", m_tuser[0], w.stream_end);
                if (m_tuser[1] !== w.overrun)
                    report("overrun", m_tuser[1], w.overrun);
            end
        end
    end

    // receiver: random stalls unless rx_calm is set, plus a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                rx_stall = rx_hold;
                rx_hold = 0;
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_calm)
                    rx_stall = pick_gap(1'b0);
            end
        end
    end

    // starts and ends just after a rising edge
    task automatic send_word(t_action act, logic [7:0] b);
        int gap;
        gap = pick_gap(tx_calm);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        predict_gz_words(act, b);
        words_sent++;
    endtask

    task automatic send_bytes(int n);
        for (int i = 0; i < n; i++)
            send_word(ACT_DATA, 8'($urandom));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (gz_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length(logic [31:0] v);
        wait_drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_length = v;
        @(posedge clk);
    endtask

    task automatic test_data_before_start();
        // length is still zero from reset, so this comes out as an overrun word
        send_word(ACT_DATA, 8'h5a);
        set_length(32'd3);
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_DATA, 8'hff);
        send_word(ACT_DATA, 8'h81);
    endtask

    task automatic test_empty_stream();
        set_length(32'd0);
        send_word(ACT_START, 8'h00);
        send_word(ACT_DATA, 8'hff);
        send_word(ACT_START, 8'hff);
    endtask

    task automatic test_short_streams();
        set_length(32'd1);
        send_word(ACT_START, 8'h00);
        send_word(ACT_DATA, 8'h00);
        set_length(32'd2);
        send_word(ACT_START, 8'h00);
        send_word(ACT_DATA, 8'hff);
        send_word(ACT_DATA, 8'ha5);
        send_word(ACT_DATA, 8'h3c);
    endtask

    task automatic test_block_sizes();
        set_length(BLOCK_MAX);
        send_word(ACT_START, 8'h00);
        send_word(ACT_DATA, 8'h12);
        // one byte past the largest block: first block is not final
        set_length(BLOCK_MAX + 1);
        send_word(ACT_START, 8'h00);
        send_bytes(2);
        set_length(32'hFFFF_FFFF);
        send_word(ACT_START, 8'h00);
        send_bytes(2);
    endtask

    task automatic test_restart_midstream();
        set_length(32'd5);
        send_word(ACT_START, 8'h00);
        send_bytes(2);
        send_word(ACT_START, 8'h00);
        send_bytes(5);
    endtask

    task automatic test_length_rewrite();
        set_length(32'd2);
        send_word(ACT_START, 8'h00);
        send_bytes(1);
        // the open block runs out before the new length, so a second block opens
        set_length(32'd5);
        send_bytes(3);
        set_length(32'd1);
        send_bytes(1);
    endtask

    task automatic test_backpressure();
        set_length(32'd40);
        tx_calm = 1;
        rx_hold = 400;
        send_word(ACT_START, 8'h00);
        send_bytes(40);
        tx_calm = 0;
        wait_drain();
    endtask

    task automatic test_random_streams();
        int r;
        int len;
        int n;
        while (words_sent < TARGET_WORDS) begin
            r = $urandom_range(0, 99);
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            if (r < 8) begin
                send_bytes($urandom_range(1, 3));
            end else if (r < 14) begin
                set_length(32'd0);
                send_word(ACT_START, 8'($urandom));
            end else if (r < 22) begin
                set_length($urandom);
                send_word(ACT_START, 8'($urandom));
                send_bytes($urandom_range(1, 6));
            end else begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                  : $urandom_range(13, 60);
                set_length(len);
                send_word(ACT_START, 8'($urandom));
                n = len;
                r = $urandom_range(0, 99);
                if (r < 15)
                    n = $urandom_range(0, len - 1);
                else if (r < 35)
                    n = len + $urandom_range(1, 3);
                send_bytes(n);
            end
        end
        tx_calm = 0;
        rx_calm = 0;
    endtask

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        errors      = 0;
        words_sent  = 0;
        cycles      = 0;
        tx_calm     = 0;
        rx_calm     = 0;
        rx_hold     = 0;
        rx_stall    = 0;
        cfg_length  = '0;
        crc_acc     = CRC_ALL_ONES;
        taken_count = '0;
        block_left  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_data_before_start();
        test_empty_stream();
        test_short_streams();
        test_block_sizes();
        test_restart_midstream();
        test_length_rewrite();
        test_backpressure();
        test_random_streams();

        wait_drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && gz_expected.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/gzsf_pkg.sv
src/gzsf_front.sv
src/gzsf_queue.sv
src/gzsf_back.sv
src/gzip_stored_block_framer.sv
src/gzsf_checker.sv
sim/tb_top.sv
